// ===== src/ebec_pkg.sv =====
// Shared types and constants for the encoder and button event classifier.
`timescale 1ns / 1ps
package ebec_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LONG   = 3'd3,
        EV_CW     = 3'd4,
        EV_CCW    = 3'd5
    } t_event;

    typedef enum logic [0:0] {
        CFG_LONG_PRESS   = 1'b0,
        CFG_DOUBLE_CLICK = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd600;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

    // Quadrature transition codes: {prev_a, prev_b, a, b}
    localparam logic [3:0] FWD_0 = 4'b1101;
    localparam logic [3:0] FWD_1 = 4'b0100;
    localparam logic [3:0] FWD_2 = 4'b0010;
    localparam logic [3:0] FWD_3 = 4'b1011;
    localparam logic [3:0] BWD_0 = 4'b1110;
    localparam logic [3:0] BWD_1 = 4'b0111;
    localparam logic [3:0] BWD_2 = 4'b0001;
    localparam logic [3:0] BWD_3 = 4'b1000;

endpackage

// ===== src/encoder_button_event_classifier_unit.sv =====
// Rotary encoder and push switch event classifier, top level.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid / o_ready) carries one poll: the two quadrature
//   levels, the switch level (low = pressed) and a wrapping millisecond stamp.
//   Output channel (o_valid / i_ready) returns exactly one event code per poll:
//   none, click, double click, long press, clockwise or counter-clockwise.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_addr
//   (0 = long press limit, 1 = double click window); write only when idle.
// Timing:
//   An accepted poll is held in the input register, then passes through the
//   classify logic into the result register.
//   Throughput is one poll per cycle while the output is not stalled; the
//   classify stage updates the tracker state in the same cycle it produces the result, so polls chain freely.
// Reset:
//   Synchronous, active low. Pipeline empties, encoder history, accumulator
//   and button timers clear, and the registers return to 600 / 300 ms.
// Backpressure:
//   A stalled result holds in the output register; the input register fills
//   and then o_ready drops until the receiver takes the result.
module encoder_button_event_classifier_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_enc_a,
    input  logic                          i_enc_b,
    input  logic                          i_switch_level,
    input  logic [ebec_pkg::TIME_W-1:0]   i_now_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_event_code,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [ebec_pkg::CFG_W-1:0]    i_cfg_data
);
    import ebec_pkg::*;

    // config registers
    logic [CFG_W-1:0]  r_long_press_ms;
    logic [CFG_W-1:0]  r_double_click_ms;

    // input register
    logic              r_s1_valid;
    logic              r_s1_a;
    logic              r_s1_b;
    logic              r_s1_sw;
    logic [TIME_W-1:0] r_s1_now;

    // tracker state
    logic [3:0]        r_pin_history;
    logic signed [2:0] r_step_accum;
    logic              r_button_held;
    logic [TIME_W-1:0] r_press_stamp;
    logic              r_click_pending;
    logic [TIME_W-1:0] r_release_stamp;

    // result register
    logic              r_out_valid;
    t_event            r_event;

    logic              s1_adv;
    logic              in_xfer;

    logic [3:0]        n_pin_history;
    logic signed [2:0] n_step_accum;
    logic              n_button_held;
    logic [TIME_W-1:0] n_press_stamp;
    logic              n_click_pending;
    logic [TIME_W-1:0] n_release_stamp;
    t_event            n_event;

    logic signed [2:0] acc_sum;
    logic              pressed;
    logic [TIME_W-1:0] held_for;
    logic [TIME_W-1:0] since_release;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_xfer = i_valid && o_ready;

    assign o_valid      = r_out_valid;
    assign o_event_code = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms   <= LONG_PRESS_RST;
            r_double_click_ms <= DOUBLE_CLICK_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_LONG_PRESS:   r_long_press_ms   <= i_cfg_data;
                CFG_DOUBLE_CLICK: r_double_click_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_a   <= i_enc_a;
            r_s1_b   <= i_enc_b;
            r_s1_sw  <= i_switch_level;
            r_s1_now <= i_now_ms;
        end
    end

    always_comb begin
        n_pin_history   = {r_pin_history[1:0], r_s1_a, r_s1_b};
        n_step_accum    = r_step_accum;
        n_button_held   = r_button_held;
        n_press_stamp   = r_press_stamp;
        n_click_pending = r_click_pending;
        n_release_stamp = r_release_stamp;
        n_event         = EV_NONE;

        pressed       = !r_s1_sw;
        held_for      = r_s1_now - r_press_stamp;
        since_release = r_s1_now - r_release_stamp;

        if (n_pin_history inside {FWD_0, FWD_1, FWD_2, FWD_3}) begin
            acc_sum = r_step_accum + 3'sd1;
        end else if (n_pin_history inside {BWD_0, BWD_1, BWD_2, BWD_3}) begin
            acc_sum = r_step_accum - 3'sd1;
        end else begin
            acc_sum = r_step_accum;
        end

        if (acc_sum >= 3'sd2) begin
            n_step_accum = 3'sd0;
            n_event      = EV_CW;
        end else if (acc_sum <= -3'sd2) begin
            n_step_accum = 3'sd0;
            n_event      = EV_CCW;
        end else begin
            n_step_accum = acc_sum;
            if (pressed && !r_button_held) begin
                n_button_held = 1'b1;
                n_press_stamp = r_s1_now;
            end
            if (!pressed && r_button_held) begin
                n_button_held = 1'b0;
                if (held_for > {{(TIME_W-CFG_W){1'b0}}, r_long_press_ms}) begin
                    n_event = EV_LONG;
                end else if (r_click_pending &&
                        since_release < {{(TIME_W-CFG_W){1'b0}}, r_double_click_ms}) begin
                    n_click_pending = 1'b0;
                    n_event         = EV_DOUBLE;
                end else begin
                    // new pending click; zero elapsed time never fires it here
                    n_click_pending = 1'b1;
                    n_release_stamp = r_s1_now;
                end
            end else if (r_click_pending &&
                    since_release > {{(TIME_W-CFG_W){1'b0}}, r_double_click_ms}) begin
                n_click_pending = 1'b0;
                n_event         = EV_CLICK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_history   <= 4'd0;
            r_step_accum    <= 3'sd0;
            r_button_held   <= 1'b0;
            r_press_stamp   <= '0;
            r_click_pending <= 1'b0;
            r_release_stamp <= '0;
        end else if (s1_adv) begin
            r_pin_history   <= n_pin_history;
            r_step_accum    <= n_step_accum;
            r_button_held   <= n_button_held;
            r_press_stamp   <= n_press_stamp;
            r_click_pending <= n_click_pending;
            r_release_stamp <= n_release_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_event <= n_event;
        end
    end

`ifndef ASSERT_OFF
    a_accum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step_accum == 3'sd0) || (r_step_accum == 3'sd1) || (r_step_accum == -3'sd1))
        else $error("step accumulator left -1..1");

    a_rot_clears_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && ((n_event == EV_CW) || (n_event == EV_CCW)) |=> (r_step_accum == 3'sd0))
        else $error("rotation event did not clear accumulator");

    a_rot_keeps_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && ((n_event == EV_CW) || (n_event == EV_CCW))
        |=> $stable(r_button_held) && $stable(r_click_pending))
        else $error("button state changed on a rotation poll");

    a_double_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (n_event == EV_DOUBLE) |=> !r_click_pending && !r_button_held)
        else $error("double click left button state set");

    a_no_pipe_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready && r_s1_valid |=> r_out_valid && r_s1_valid)
        else $error("stalled result dropped");
`endif

endmodule
